@@ hdl/nfs_pkg.sv @@
package nfs_pkg;

  localparam int DIV_BITS = 40;  // |dy * ox| * 256 < 2^40

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic signed [41:0] Y_MAX = 42'sd8388607;
  localparam logic signed [41:0] Y_MIN = -42'sd8388608;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] seg_left_x;
    logic signed [15:0] seg_left_y;
    logic signed [15:0] seg_right_x;
    logic signed [15:0] seg_right_y;
    logic signed [15:0] query_x;
    logic signed [23:0] query_y;
    logic [9:0]         half_width;
  } nfs_req_t;

  typedef struct packed {
    logic               found;
    logic signed [23:0] floor_y;
    logic               table_overflow;
  } nfs_rsp_t;

  // One segment travelling down the divider row.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                match;
    logic                zero;
    logic                neg;
    logic signed [15:0]  ly;
    logic [15:0]         den;
    logic [15:0]         rem;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] quo;
  } div_tok_t;

endpackage

@@ hdl/nfs_div_cell.sv @@
module nfs_div_cell import nfs_pkg::*; #(
  parameter int POS = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  div_tok_t tok_in,
  output div_tok_t tok_out
);

  logic [16:0] trial;
  div_tok_t    tok_next;

  // one restoring step: quotient bit POS
  always_comb begin
    trial    = {tok_in.rem, tok_in.num[POS]};
    tok_next = tok_in;
    if (trial >= {1'b0, tok_in.den}) begin
      tok_next.rem      = 16'(trial - {1'b0, tok_in.den});
      tok_next.quo[POS] = 1'b1;
    end else begin
      tok_next.rem = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ hdl/nfs_div_chain.sv @@
module nfs_div_chain import nfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_tok_t tok_in,
  output div_tok_t tok_out
);

  div_tok_t link [DIV_BITS+1];

  assign link[0] = tok_in;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
    nfs_div_cell #(.POS(DIV_BITS - 1 - k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (link[k]),
      .tok_out(link[k+1])
    );
  end

  assign tok_out = link[DIV_BITS];

endmodule

@@ hdl/nearest_floor_segment_search_top.sv @@
// Nearest floor segment search.
//
// Request channel: a request (req) is taken on a rising edge with start high
// and busy low. req.mode picks add segment, query floor or clear table.
// Response channel: done strobes for one cycle with rsp valid; there is no
// back pressure, the receiver must take it.
//
// Add, clear and the unused mode answer on the cycle after the request, and
// busy stays low, so these can go back to back. A query against an empty
// table answers the same way. A query against N stored segments holds busy
// until it raises done: one segment per cycle is read from the segment
// memory, multiplied, then walked through a row of 40 divider cells (one
// quotient bit per cell), then compared against the running best.
//
// Reset clears the segment count and the sequencer; the segment memory is not
// cleared (only entries below the count are ever read).
// Adding to a full table drops the segment and flags table_overflow.
module nearest_floor_segment_search_top import nfs_pkg::*; #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  nfs_req_t req,
  output logic     done,
  output nfs_rsp_t rsp
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue_cnt;
  logic             issuing;
  logic             accept;
  logic             done_next;

  // query operands held for the scan
  logic signed [15:0] qx;
  logic signed [23:0] qy;
  logic [9:0]         hw;

  // running best
  logic               have;
  logic signed [24:0] best_dist;
  logic signed [23:0] best_y;

  logic [63:0] mem [MAX_SEGMENTS];

  assign busy   = (state == ST_SCAN);
  assign accept = start && !busy;

  // ---- memory: write on add, registered read during scan ----
  logic [63:0] rd_data;
  logic        rd_valid, rd_last;

  always_ff @(posedge clk) begin
    if (accept && req.mode == MODE_ADD && count < CNT_W'(MAX_SEGMENTS)) begin
      mem[count[IDX_W-1:0]] <= {req.seg_right_y, req.seg_right_x,
                                req.seg_left_y, req.seg_left_x};
    end
    if (issuing) begin
      rd_data <= mem[issue_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= issue_cnt == count - CNT_W'(1);
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issuing;
    end
  end

  // ---- stage 1: span test and dy * ox ----
  logic signed [15:0] lx, ly, rx, ry;
  logic signed [16:0] dx_c, dy_c, ox_c;
  logic signed [17:0] lo_lim, hi_lim, qx_w;
  logic               match_c;

  assign lx      = rd_data[15:0];
  assign ly      = rd_data[31:16];
  assign rx      = rd_data[47:32];
  assign ry      = rd_data[63:48];
  assign dx_c    = 17'(rx) - 17'(lx);
  assign dy_c    = 17'(ry) - 17'(ly);
  assign ox_c    = 17'(qx) - 17'(lx);
  assign qx_w    = 18'(qx);
  assign lo_lim  = 18'(lx) - $signed({8'b0, hw});
  assign hi_lim  = 18'(rx) + $signed({8'b0, hw});
  assign match_c = (qx_w > lo_lim) && (qx_w < hi_lim);

  logic signed [33:0] s2_prod;
  logic signed [16:0] s2_dx;
  logic signed [15:0] s2_ly;
  logic               s2_match, s2_valid, s2_last;

  always_ff @(posedge clk) begin
    s2_prod  <= dy_c * ox_c;
    s2_dx    <= dx_c;
    s2_ly    <= ly;
    s2_match <= match_c;
    s2_last  <= rd_last;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= rd_valid;
    end
  end

  // ---- stage 2: magnitudes and sign into the divider row ----
  logic [33:0] prod_mag;
  logic [16:0] dx_mag;
  div_tok_t    tok_in, tok_out;

  assign prod_mag = s2_prod[33] ? 34'(-s2_prod) : 34'(s2_prod);
  assign dx_mag   = s2_dx[16] ? 17'(-s2_dx) : 17'(s2_dx);

  always_comb begin
    tok_in       = '0;
    tok_in.valid = s2_valid;
    tok_in.last  = s2_last;
    tok_in.match = s2_match;
    tok_in.zero  = (s2_dx == 17'sd0);
    tok_in.neg   = s2_prod[33] ^ s2_dx[16];
    tok_in.ly    = s2_ly;
    tok_in.den   = dx_mag[15:0];
    tok_in.num   = {prod_mag[31:0], 8'b0};
  end

  nfs_div_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .tok_in (tok_in),
    .tok_out(tok_out)
  );

  // ---- final: line y, saturate, nearest-below pick ----
  logic signed [40:0] q_s;
  logic signed [41:0] y_full;
  logic signed [23:0] y_sat;
  logic signed [24:0] margin;
  logic               better;

  always_comb begin
    q_s = $signed({1'b0, tok_out.quo});
    if (tok_out.neg) begin
      q_s = -q_s;
    end
    if (tok_out.zero) begin
      q_s = '0;
    end
    y_full = $signed({{18{tok_out.ly[15]}}, tok_out.ly, 8'b0}) + 42'(q_s);
    if (y_full > Y_MAX) begin
      y_sat = 24'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_sat = 24'(Y_MIN);
    end else begin
      y_sat = y_full[23:0];
    end
    margin = 25'(y_sat) - 25'(qy);
    better = tok_out.valid && tok_out.match && (margin > 25'sd0)
             && (!have || margin < best_dist);
  end

  // done: immediate answer for everything but a query with segments,
  // otherwise when the last segment leaves the divider row
  always_comb begin
    done_next = (accept && !(req.mode == MODE_QUERY && count != '0))
                || (state == ST_SCAN && tok_out.valid && tok_out.last);
  end

  // ---- sequencer and response ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      issuing   <= 1'b0;
      issue_cnt <= '0;
      have      <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= done_next;
      if (issuing) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
        if (issue_cnt == count - CNT_W'(1)) begin
          issuing <= 1'b0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rsp.found          <= 1'b0;
            rsp.floor_y        <= '0;
            rsp.table_overflow <= (req.mode == MODE_ADD)
                                  && (count >= CNT_W'(MAX_SEGMENTS));
            unique case (req.mode)
              MODE_ADD: begin
                if (count < CNT_W'(MAX_SEGMENTS)) begin
                  count <= count + CNT_W'(1);
                end
              end
              MODE_QUERY: begin
                qx <= req.query_x;
                qy <= req.query_y;
                hw <= req.half_width;
                have <= 1'b0;
                if (count != '0) begin
                  state     <= ST_SCAN;
                  issuing   <= 1'b1;
                  issue_cnt <= '0;
                end
              end
              MODE_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (better) begin
            have      <= 1'b1;
            best_dist <= margin;
            best_y    <= y_sat;
          end
          if (tok_out.valid && tok_out.last) begin
            state              <= ST_IDLE;
            rsp.table_overflow <= 1'b0;
            if (better) begin
              rsp.found   <= 1'b1;
              rsp.floor_y <= y_sat;
            end else begin
              rsp.found   <= have;
              rsp.floor_y <= have ? best_y : 24'sd0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- checks ----
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count past table size");

  a_chain_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid |-> state == ST_SCAN)
    else $error("divider output outside a scan");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response while still scanning");

  a_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    done && rsp.table_overflow |-> !rsp.found)
    else $error("overflow and found together");

endmodule
